/* hw/rtl/ecou_pkg.sv */
// ecou_pkg: types, constants and the cordic angle table for the camera unit
// no dependencies

package ecou_pkg;

	localparam int FRAC_BITS = 16;

	typedef enum logic [2:0] {
		OP_MOUSE  = 3'd0,
		OP_KEY    = 3'd1,
		OP_SCROLL = 3'd2,
		OP_SETPOS = 3'd3,
		OP_REINIT = 3'd4
	} opcode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_TURN,
		ST_CORDIC_Y,
		ST_CORDIC_P,
		ST_MUL,
		ST_KEY_MUL,
		ST_KEY_AXIS,
		ST_OUT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load_in;
		logic do_turn;
		logic do_reinit;
		logic do_scroll;
		logic do_setpos;
		logic cordic_init;
		logic cordic_step;
		logic cordic_save_y;
		logic cordic_save_p;
		logic mul_step;
		logic key_vel;
		logic key_axis;
	} cmd_t;

	typedef struct packed {
		opcode_t op;
		logic    last_step;
		logic    mul_done;
		logic    axis_done;
	} status_t;

	typedef logic signed [31:0] atan_t;

	function automatic atan_t atan_deg24(input logic [4:0] i);
		atan_t r;
		r = '0;
		case (i)
			5'd0: r = 754974720;  5'd1: r = 445687602;  5'd2: r = 235489088;
			5'd3: r = 119537938;  5'd4: r = 60000934;   5'd5: r = 30029717;
			5'd6: r = 15018523;   5'd7: r = 7509720;    5'd8: r = 3754917;
			5'd9: r = 1877466;    5'd10: r = 938734;    5'd11: r = 469367;
			5'd12: r = 234684;    5'd13: r = 117342;    5'd14: r = 58671;
			5'd15: r = 29335;     5'd16: r = 14668;     5'd17: r = 7334;
			5'd18: r = 3667;      5'd19: r = 1833;      5'd20: r = 917;
			5'd21: r = 458;       5'd22: r = 229;       5'd23: r = 115;
			5'd24: r = 57;        5'd25: r = 29;        5'd26: r = 14;
			5'd27: r = 7;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* hw/rtl/ecou_if.sv */
// ecou_if: valid/ready channel interfaces for event and result words
// no dependencies; field widths are written out in each interface

interface ecou_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [15:0] mouse_x;
	logic [15:0] mouse_y;
	logic [1:0]  direction;
	logic [15:0] delta_time;
	logic signed [23:0] scroll_offset;
	modport source (output valid, opcode, mouse_x, mouse_y, direction, delta_time,
		scroll_offset, input ready);
	modport sink (input valid, opcode, mouse_x, mouse_y, direction, delta_time,
		scroll_offset, output ready);
endinterface

interface ecou_out_if;
	logic valid;
	logic ready;
	logic signed [17:0] look_x;
	logic signed [17:0] look_y;
	logic signed [17:0] look_z;
	logic signed [17:0] up_x;
	logic signed [17:0] up_y;
	logic signed [17:0] up_z;
	logic signed [31:0] eye_x;
	logic signed [31:0] eye_y;
	logic signed [31:0] eye_z;
	logic [21:0] zoom;
	logic signed [25:0] yaw;
	logic signed [25:0] pitch;
	modport source (output valid, look_x, look_y, look_z, up_x, up_y, up_z,
		eye_x, eye_y, eye_z, zoom, yaw, pitch, input ready);
	modport sink (input valid, look_x, look_y, look_z, up_x, up_y, up_z,
		eye_x, eye_y, eye_z, zoom, yaw, pitch, output ready);
endinterface

/* hw/rtl/euler_camera_orientation_unit.sv */
// euler_camera_orientation_unit: top level with apb registers and output register
// depends on ecou_pkg, ecou_if, ecou_ctrl, ecou_dp

// Fly camera driven by event words, one result word per event. A mouse move or
// reinit runs two CORDIC rotations of CORDIC_STEPS iterations each on one shared
// unit, then five rebuild steps on one multiplier. A key move updates one eye
// axis per cycle. One event is in work at a time; the result sits in an output
// register until taken.
module euler_camera_orientation_unit import ecou_pkg::*; #(
	parameter int CORDIC_STEPS = 18
) (
	input  logic clk,
	input  logic arst_n,
	ecou_in_if.sink    in_ch,
	ecou_out_if.source out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [2:0] R_SPEED = 3'd0, R_SENS = 3'd1, R_YAW = 3'd2, R_PITCH = 3'd3,
		R_ZOOM = 3'd4, R_X = 3'd5, R_Y = 3'd6, R_Z = 3'd7;

	logic [23:0] speed_q;
	logic [15:0] sens_q;
	logic signed [25:0] syaw_q, spitch_q;
	logic [21:0] szoom_q;
	logic signed [31:0] sx_q, sy_q, sz_q;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= 24'd163840; sens_q <= 16'd6554;
			syaw_q <= -26'sd5898240; spitch_q <= '0; szoom_q <= 22'd2949120;
			sx_q <= '0; sy_q <= '0; sz_q <= '0;
		end else if (wr) begin
			case (paddr[4:2])
				R_SPEED: speed_q <= pwdata[23:0];
				R_SENS:  sens_q <= pwdata[15:0];
				R_YAW:   syaw_q <= pwdata[25:0];
				R_PITCH: spitch_q <= pwdata[25:0];
				R_ZOOM:  szoom_q <= pwdata[21:0];
				R_X:     sx_q <= pwdata;
				R_Y:     sy_q <= pwdata;
				R_Z:     sz_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			R_SPEED: prdata = {8'd0, speed_q};
			R_SENS:  prdata = {16'd0, sens_q};
			R_YAW:   prdata = 32'(syaw_q);
			R_PITCH: prdata = 32'(spitch_q);
			R_ZOOM:  prdata = {10'd0, szoom_q};
			R_X:     prdata = sx_q;
			R_Y:     prdata = sy_q;
			R_Z:     prdata = sz_q;
			default: prdata = '0;
		endcase
	end

	cmd_t cmd;
	status_t status;
	logic out_load, ovalid_q;
	logic signed [17:0] look [3];
	logic signed [17:0] up [3];
	logic signed [31:0] eye [3];
	logic [21:0] zoom;
	logic signed [25:0] yaw, pitch;

	ecou_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_load, .out_busy(ovalid_q && !out_ch.ready),
		.status, .cmd
	);

	ecou_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
		.clk, .arst_n, .cmd, .status,
		.opcode(in_ch.opcode), .mouse_x(in_ch.mouse_x), .mouse_y(in_ch.mouse_y),
		.direction(in_ch.direction), .delta_time(in_ch.delta_time),
		.scroll_offset(in_ch.scroll_offset),
		.movement_speed(speed_q), .mouse_sensitivity(sens_q),
		.start_yaw(syaw_q), .start_pitch(spitch_q), .start_zoom(szoom_q),
		.start_x(sx_q), .start_y(sy_q), .start_z(sz_q),
		.look_q(look), .up_q(up), .eye_q(eye), .zoom_q(zoom), .yaw_q(yaw), .pitch_q(pitch)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_load) begin
			ovalid_q <= 1'b1;
		end else if (out_ch.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ch.look_x <= look[0]; out_ch.look_y <= look[1]; out_ch.look_z <= look[2];
			out_ch.up_x <= up[0]; out_ch.up_y <= up[1]; out_ch.up_z <= up[2];
			out_ch.eye_x <= eye[0]; out_ch.eye_y <= eye[1]; out_ch.eye_z <= eye[2];
			out_ch.zoom <= zoom; out_ch.yaw <= yaw; out_ch.pitch <= pitch;
		end
	end

	assign out_ch.valid = ovalid_q;

`ifndef SYNTH
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!ovalid_q || out_ch.ready)) else $error("result overwritten");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready) else $error("second word taken");
	a_zoom_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.zoom >= 22'd65536 && out_ch.zoom <= 22'd2949120))
		else $error("zoom out of range");
`endif

endmodule

/* hw/rtl/ecou_ctrl.sv */
// ecou_ctrl: sequencing state machine for the camera unit
// depends on ecou_pkg

module ecou_ctrl import ecou_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_load,
	input  logic    out_busy,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_next = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (status.op)
					OP_MOUSE: begin
						cmd.do_turn = 1'b1;
						state_next = ST_TURN;
					end
					OP_KEY: begin
						cmd.key_vel = 1'b1;
						state_next = ST_KEY_MUL;
					end
					OP_SCROLL: begin
						cmd.do_scroll = 1'b1;
						state_next = ST_OUT;
					end
					OP_SETPOS: begin
						cmd.do_setpos = 1'b1;
						state_next = ST_OUT;
					end
					OP_REINIT: begin
						cmd.do_reinit = 1'b1;
						state_next = ST_TURN;
					end
					default: state_next = ST_OUT;
				endcase
			end
			ST_TURN: begin
				// angles settled, start the yaw rotation
				cmd.cordic_init = 1'b1;
				state_next = ST_CORDIC_Y;
			end
			ST_CORDIC_Y: begin
				cmd.cordic_step = 1'b1;
				if (status.last_step) begin
					cmd.cordic_save_y = 1'b1;
					state_next = ST_CORDIC_P;
				end
			end
			ST_CORDIC_P: begin
				cmd.cordic_step = 1'b1;
				if (status.last_step) begin
					cmd.cordic_save_p = 1'b1;
					state_next = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (status.mul_done) begin
					state_next = ST_OUT;
				end
			end
			ST_KEY_MUL: begin
				state_next = ST_KEY_AXIS;
			end
			ST_KEY_AXIS: begin
				cmd.key_axis = 1'b1;
				if (status.axis_done) begin
					state_next = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_busy) begin
					out_load = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

endmodule

/* hw/rtl/ecou_dp.sv */
// ecou_dp: camera state, turn/zoom/eye arithmetic, shared cordic and multiplier
// depends on ecou_pkg

module ecou_dp import ecou_pkg::*; #(
	parameter int CORDIC_STEPS = 18
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	output status_t status,
	input  logic [2:0]  opcode,
	input  logic [15:0] mouse_x,
	input  logic [15:0] mouse_y,
	input  logic [1:0]  direction,
	input  logic [15:0] delta_time,
	input  logic signed [23:0] scroll_offset,
	input  logic [23:0] movement_speed,
	input  logic [15:0] mouse_sensitivity,
	input  logic signed [25:0] start_yaw,
	input  logic signed [25:0] start_pitch,
	input  logic [21:0] start_zoom,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] start_z,
	output logic signed [17:0] look_q [3],
	output logic signed [17:0] up_q [3],
	output logic signed [31:0] eye_q [3],
	output logic [21:0] zoom_q,
	output logic signed [25:0] yaw_q,
	output logic signed [25:0] pitch_q
);

	localparam int ZSH = 24 - FRAC_BITS;
	localparam int SW  = 5;
	localparam logic signed [39:0] FULL    = 40'sd360 <<< FRAC_BITS;
	localparam logic signed [39:0] HALF    = 40'sd180 <<< FRAC_BITS;
	localparam logic signed [39:0] QUARTER = 40'sd90 <<< FRAC_BITS;
	localparam logic signed [39:0] ANGMAX  = 40'sd33554431;
	localparam logic signed [39:0] ANGMIN  = -40'sd33554432;
	localparam logic signed [39:0] ZMIN    = 40'sd1 <<< FRAC_BITS;
	localparam logic signed [39:0] ZMAX    = 40'sd45 <<< FRAC_BITS;
	localparam logic signed [33:0] GAIN    = 34'sd652032874;
	localparam logic [SW-1:0] LAST = SW'(((CORDIC_STEPS < 28) ? CORDIC_STEPS : 28) - 1);
	localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

	opcode_t op_q;
	logic [15:0] lm_q [2];
	logic [15:0] mx_q, my_q, dt_q;
	logic [1:0]  dir_q;
	logic signed [23:0] scr_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic neg_q;
	logic [SW-1:0] it_q;
	logic signed [33:0] cyaw_q, syaw_q, cpit_q, spit_q;
	logic [2:0] mi_q;
	logic signed [31:0] vel_q;
	logic [1:0] ax_q;

	function automatic logic signed [39:0] clamp40(input logic signed [39:0] v,
		input logic signed [39:0] lo, input logic signed [39:0] hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic logic signed [25:0] turn(input logic signed [25:0] ang,
		input logic [15:0] m, input logic [15:0] last, input logic [15:0] sens);
		logic signed [16:0] d;
		logic signed [39:0] ch, v;
		d = $signed({1'b0, m}) - $signed({1'b0, last});
		ch = clamp40(40'(d * $signed({1'b0, sens})), -FULL, FULL);
		v = 40'(ang) + ch;
		if (v > FULL) v = v - FULL;
		else if (v < -FULL) v = v + FULL;
		return 26'(clamp40(v, ANGMIN, ANGMAX));
	endfunction

	// reduce to [-90,90] degrees, q.24, report fold
	function automatic logic signed [34:0] reduce(input logic signed [25:0] a);
		logic signed [39:0] r;
		logic neg;
		r = 40'(a);
		neg = 1'b0;
		// |a| < 2^25 < 2*full only when full large; use up to two corrections
		if (r >= FULL) r = r - FULL;
		if (r >= FULL) r = r - FULL;
		if (r < 0) r = r + FULL;
		if (r < 0) r = r + FULL;
		if (r >= HALF) r = r - FULL;
		if (r > QUARTER) begin
			r = HALF - r; neg = 1'b1;
		end else if (r < -QUARTER) begin
			r = -HALF - r; neg = 1'b1;
		end
		return {neg, 34'(r <<< ZSH)};
	endfunction

	function automatic logic signed [17:0] to_unit(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = (v + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
		if (r > ONE) r = ONE;
		if (r < -ONE) r = -ONE;
		return 18'(r);
	endfunction

	function automatic logic signed [63:0] mul30(input logic signed [33:0] a,
		input logic signed [33:0] b);
		return (64'(a) * 64'(b) + (64'sd1 <<< 29)) >>> 30;
	endfunction

	logic signed [34:0] red;
	logic signed [33:0] nx, ny, nz, atn;
	assign atn = 34'(atan_deg24(it_q));
	always_comb begin
		if (cz_q >= 0) begin
			nx = cx_q - (cy_q >>> it_q);
			ny = cy_q + (cx_q >>> it_q);
			nz = cz_q - atn;
		end else begin
			nx = cx_q + (cy_q >>> it_q);
			ny = cy_q - (cx_q >>> it_q);
			nz = cz_q + atn;
		end
	end

	logic signed [33:0] fcos;
	assign fcos = neg_q ? -nx : nx;
	assign red = reduce(cmd.cordic_save_y ? pitch_q : yaw_q);
	assign status.op = op_q;
	assign status.last_step = (it_q == LAST);
	assign status.mul_done = (mi_q == 3'd4);
	assign status.axis_done = (ax_q == 2'd2);

	// product for vector rebuild, one per cycle
	logic sgn;
	logic signed [63:0] prod;
	assign sgn = cpit_q < 0;
	always_comb begin
		case (mi_q)
			3'd0: prod = mul30(cyaw_q, cpit_q);
			3'd1: prod = mul30(syaw_q, cpit_q);
			3'd2: prod = mul30(cyaw_q, spit_q);
			3'd3: prod = mul30(syaw_q, spit_q);
			default: prod = '0;
		endcase
	end

	// key move: one axis per cycle, right vector from saved yaw sin/cos and pitch cos sign
	logic signed [17:0] kvec;
	logic signed [63:0] kd, ke;
	logic ksub;
	always_comb begin
		kvec = dir_q[1] ? ((ax_q == 2'd1) ? 18'sd0 : (ax_q == 2'd0) ?
			to_unit(sgn ? 64'(syaw_q) : -64'(syaw_q)) :
			to_unit(sgn ? -64'(cyaw_q) : 64'(cyaw_q))) : look_q[ax_q];
		ksub = (dir_q == 2'd1) || (dir_q == 2'd2);
		kd = (64'(vel_q) * 64'(kvec)) >>> FRAC_BITS;
		ke = ksub ? 64'(eye_q[ax_q]) - kd : 64'(eye_q[ax_q]) + kd;
		if (ke > 64'sd2147483647) ke = 64'sd2147483647;
		if (ke < -64'sd2147483648) ke = -64'sd2147483648;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_q <= -26'sd5898240;
			pitch_q <= '0;
			zoom_q <= 22'd2949120;
			lm_q[0] <= '0; lm_q[1] <= '0;
			eye_q[0] <= '0; eye_q[1] <= '0; eye_q[2] <= '0;
			look_q[0] <= '0; look_q[1] <= '0; look_q[2] <= -18'sd65536;
			up_q[0] <= '0; up_q[1] <= 18'sd65536; up_q[2] <= '0;
			cyaw_q <= '0; syaw_q <= -34'sd1073741824;
			cpit_q <= 34'sd1073741824; spit_q <= '0;
			it_q <= '0; mi_q <= '0; ax_q <= '0;
		end else begin
			if (cmd.do_turn) begin
				yaw_q <= turn(yaw_q, mx_q, lm_q[0], mouse_sensitivity);
				pitch_q <= turn(pitch_q, my_q, lm_q[1], mouse_sensitivity);
				lm_q[0] <= mx_q; lm_q[1] <= my_q;
			end
			if (cmd.do_setpos) begin
				lm_q[0] <= mx_q; lm_q[1] <= my_q;
			end
			if (cmd.do_scroll) begin
				zoom_q <= 22'(clamp40(40'(zoom_q) - 40'(scr_q), ZMIN, ZMAX));
			end
			if (cmd.do_reinit) begin
				yaw_q <= start_yaw;
				pitch_q <= start_pitch;
				zoom_q <= 22'(clamp40(40'(start_zoom), ZMIN, ZMAX));
				eye_q[0] <= start_x; eye_q[1] <= start_y; eye_q[2] <= start_z;
			end
			if (cmd.cordic_init || cmd.cordic_save_y) begin
				it_q <= '0;
			end else if (cmd.cordic_step) begin
				it_q <= it_q + SW'(1);
			end
			if (cmd.cordic_save_y) begin
				cyaw_q <= fcos; syaw_q <= ny;
			end
			if (cmd.cordic_save_p) begin
				cpit_q <= fcos; spit_q <= ny;
				mi_q <= '0;
			end
			if (cmd.mul_step) begin
				mi_q <= mi_q + 3'd1;
				case (mi_q)
					3'd0: look_q[0] <= to_unit(prod);
					3'd1: look_q[2] <= to_unit(prod);
					3'd2: up_q[0] <= to_unit(sgn ? prod : -prod);
					3'd3: up_q[2] <= to_unit(sgn ? prod : -prod);
					default: begin
						look_q[1] <= to_unit(64'(spit_q));
						up_q[1] <= to_unit(sgn ? -64'(cpit_q) : 64'(cpit_q));
					end
				endcase
			end
			if (cmd.key_vel) begin
				ax_q <= '0;
			end
			if (cmd.key_axis) begin
				eye_q[ax_q] <= 32'(ke);
				ax_q <= ax_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q <= opcode_t'(opcode);
			mx_q <= mouse_x; my_q <= mouse_y;
			dir_q <= direction; dt_q <= delta_time; scr_q <= scroll_offset;
		end
		if (cmd.key_vel) begin
			vel_q <= 32'((48'(movement_speed) * 48'(dt_q)) >> FRAC_BITS);
		end
		if (cmd.cordic_init || cmd.cordic_save_y) begin
			cx_q <= GAIN; cy_q <= '0;
			cz_q <= red[33:0]; neg_q <= red[34];
		end else if (cmd.cordic_step) begin
			cx_q <= nx; cy_q <= ny; cz_q <= nz;
		end
	end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking regression of the euler camera unit, event words in, pose words out
// depends on ecou_pkg, ecou_if and euler_camera_orientation_unit

module testbench;
	import ecou_pkg::*;

	localparam int  FB        = 16;
	localparam int  STEPS     = 18;
	localparam longint FULL_TURN = longint'(360) << FB;
	localparam longint ONE_DEG   = longint'(1) << FB;
	localparam longint CORDIC_X0 = 652032874;
	localparam int  LIMIT     = 2000000;
	localparam int  SETTLE    = 80;

	// register byte addresses
	localparam logic [4:0] REG_SPEED = 5'd0,  REG_SENS = 5'd4,  REG_YAW0 = 5'd8;
	localparam logic [4:0] REG_PITCH0 = 5'd12, REG_ZOOM0 = 5'd16, REG_X0 = 5'd20;
	localparam logic [4:0] REG_Y0 = 5'd24, REG_Z0 = 5'd28;

	localparam logic [1:0] DIR_FWD = 2'd0, DIR_BACK = 2'd1, DIR_LEFT = 2'd2, DIR_RIGHT = 2'd3;
	localparam logic [2:0] OP_SPARE5 = 3'd5, OP_SPARE6 = 3'd6, OP_SPARE7 = 3'd7;

	localparam longint ATAN_TAB [0:27] = '{
		754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
		15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
		58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

	typedef struct {
		logic [2:0]         op;
		logic [15:0]        mx;
		logic [15:0]        my;
		logic [1:0]         dir;
		logic [15:0]        dt;
		logic signed [23:0] scr;
	} event_t;

	// look xyz, up xyz, eye xyz, zoom, yaw, pitch
	typedef struct {
		longint f [12];
	} pose_t;

	typedef struct {
		event_t     ev;
		bit         fixed;
		logic [21:0]        zoom;
		logic signed [25:0] yaw;
		logic signed [25:0] pitch;
	} step_row_t;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [4:0]  paddr;
	logic [31:0] pwdata, prdata;

	ecou_in_if  in_ch ();
	ecou_out_if out_ch ();

	euler_camera_orientation_unit DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// camera shadow state and register copies
	logic [23:0]        speed_q;
	logic [15:0]        sens_q;
	logic signed [25:0] yaw0_q, pitch0_q;
	logic [21:0]        zoom0_q;
	logic signed [31:0] x0_q, y0_q, z0_q;
	longint cam_yaw, cam_pitch, cam_zoom, last_mx, last_my;
	longint eye [3], look [3], rgt [3], upv [3];

	pose_t pending_poses [$];
	int    err_cnt = 0;
	int    cycle_cnt = 0;
	int    sender_idle_pct = 0, recv_stall_pct = 0, hold_cnt = 0;

	string field_name [12] = '{"look_x", "look_y", "look_z", "up_x", "up_y", "up_z",
		"eye_x", "eye_y", "eye_z", "zoom", "yaw", "pitch"};

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint rnd_mul30(longint a, longint b);
		return (a * b + (longint'(1) << 29)) >>> 30;
	endfunction

	function automatic longint unit_q(longint v);
		return clip((v + (longint'(1) << (29 - FB))) >>> (30 - FB), -ONE_DEG, ONE_DEG);
	endfunction

	function automatic void cordic_sc(input longint a, output longint c, output longint s);
		longint half, quarter, r, x, y, z, nx;
		bit     flip;
		half = FULL_TURN / 2;
		quarter = FULL_TURN / 4;
		r = a % FULL_TURN;
		flip = 0;
		if (r < 0) r += FULL_TURN;
		if (r >= half) r -= FULL_TURN;
		if (r > quarter) begin
			r = half - r;
			flip = 1;
		end else if (r < -quarter) begin
			r = -half - r;
			flip = 1;
		end
		x = CORDIC_X0;
		y = 0;
		z = r * (longint'(1) << (24 - FB));
		for (int i = 0; i < STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= ATAN_TAB[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += ATAN_TAB[i];
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = y;
	endfunction

	function automatic void rebuild_axes();
		longint cy, sy, cp, sp, sg;
		cordic_sc(cam_yaw, cy, sy);
		cordic_sc(cam_pitch, cp, sp);
		// pitch past vertical flips right and up
		sg = cp < 0 ? -1 : 1;
		look[0] = unit_q(rnd_mul30(cy, cp));
		look[1] = unit_q(sp);
		look[2] = unit_q(rnd_mul30(sy, cp));
		rgt[0] = unit_q(-sg * sy);
		rgt[1] = 0;
		rgt[2] = unit_q(sg * cy);
		upv[0] = unit_q(-sg * rnd_mul30(cy, sp));
		upv[1] = unit_q(sg * cp);
		upv[2] = unit_q(-sg * rnd_mul30(sy, sp));
	endfunction

	function automatic longint turn_angle(longint ang, longint delta, longint sens);
		longint v;
		v = ang + clip(delta * sens, -FULL_TURN, FULL_TURN);
		if (v > FULL_TURN) v -= FULL_TURN;
		else if (v < -FULL_TURN) v += FULL_TURN;
		return clip(v, -(longint'(1) << 25), (longint'(1) << 25) - 1);
	endfunction

	function automatic void reload_camera();
		cam_yaw = longint'(yaw0_q);
		cam_pitch = longint'(pitch0_q);
		cam_zoom = clip(longint'(zoom0_q), ONE_DEG, 45 * ONE_DEG);
		eye[0] = longint'(x0_q);
		eye[1] = longint'(y0_q);
		eye[2] = longint'(z0_q);
		rebuild_axes();
	endfunction

	function automatic pose_t apply_event(event_t ev);
		pose_t  p;
		longint vel, d, e;
		case (ev.op)
			OP_MOUSE: begin
				cam_yaw = turn_angle(cam_yaw, longint'(ev.mx) - last_mx, longint'(sens_q));
				cam_pitch = turn_angle(cam_pitch, longint'(ev.my) - last_my, longint'(sens_q));
				last_mx = ev.mx;
				last_my = ev.my;
				rebuild_axes();
			end
			OP_KEY: begin
				vel = (longint'(speed_q) * longint'(ev.dt)) >>> FB;
				for (int i = 0; i < 3; i++) begin
					d = (vel * (ev.dir inside {DIR_FWD, DIR_BACK} ? look[i] : rgt[i])) >>> FB;
					e = (ev.dir inside {DIR_BACK, DIR_LEFT}) ? eye[i] - d : eye[i] + d;
					eye[i] = clip(e, -(longint'(1) << 31), (longint'(1) << 31) - 1);
				end
			end
			OP_SCROLL: cam_zoom = clip(cam_zoom - longint'(ev.scr), ONE_DEG, 45 * ONE_DEG);
			OP_SETPOS: begin
				last_mx = ev.mx;
				last_my = ev.my;
			end
			OP_REINIT: reload_camera();
			default: ;
		endcase
		for (int i = 0; i < 3; i++) begin
			p.f[i] = look[i];
			p.f[3 + i] = upv[i];
			p.f[6 + i] = eye[i];
		end
		p.f[9] = cam_zoom;
		p.f[10] = cam_yaw;
		p.f[11] = cam_pitch;
		return p;
	endfunction

	// clock and cycle limit
	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT) begin
			$display("euler_camera_orientation_unit regression: fail");
			$finish;
		end
	end

	// result side: stalls and long hold-offs
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ch.ready = 1'b0;
		end else begin
			out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		pose_t want, got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.f = '{longint'(out_ch.look_x), longint'(out_ch.look_y), longint'(out_ch.look_z),
				longint'(out_ch.up_x), longint'(out_ch.up_y), longint'(out_ch.up_z),
				longint'(out_ch.eye_x), longint'(out_ch.eye_y), longint'(out_ch.eye_z),
				longint'(out_ch.zoom), longint'(out_ch.yaw), longint'(out_ch.pitch)};
			if (pending_poses.size() == 0) begin
				$display("%0t: unexpected pose word, yaw %0d", $time, got.f[10]);
				err_cnt++;
			end else begin
				want = pending_poses.pop_front();
				for (int i = 0; i < 12; i++)
					if (want.f[i] != got.f[i]) begin
						$display("%0t: %s expected %0d actual %0d", $time, field_name[i],
							want.f[i], got.f[i]);
						err_cnt++;
					end
			end
		end
	end

	task automatic reg_write(input logic [4:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
	endtask

	task automatic load_regs(input logic [23:0] spd, input logic [15:0] sns,
		input logic signed [25:0] y0, input logic signed [25:0] p0, input logic [21:0] z0,
		input logic signed [31:0] ex, input logic signed [31:0] ey, input logic signed [31:0] ez);
		// wait for the unit to go quiet before touching registers
		wait (pending_poses.size() == 0);
		repeat (SETTLE) @(negedge clk);
		reg_write(REG_SPEED, 32'(spd));   speed_q = spd;
		reg_write(REG_SENS, 32'(sns));    sens_q = sns;
		reg_write(REG_YAW0, 32'(y0));     yaw0_q = y0;
		reg_write(REG_PITCH0, 32'(p0));   pitch0_q = p0;
		reg_write(REG_ZOOM0, 32'(z0));    zoom0_q = z0;
		reg_write(REG_X0, ex);            x0_q = ex;
		reg_write(REG_Y0, ey);            y0_q = ey;
		reg_write(REG_Z0, ez);            z0_q = ez;
	endtask

	task automatic send_event(input event_t ev, input bit fixed, input logic [21:0] zm,
		input logic signed [25:0] yw, input logic signed [25:0] pt);
		pose_t p;
		while ($urandom_range(99) < sender_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.opcode = ev.op; in_ch.mouse_x = ev.mx; in_ch.mouse_y = ev.my;
		in_ch.direction = ev.dir; in_ch.delta_time = ev.dt; in_ch.scroll_offset = ev.scr;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		p = apply_event(ev);
		if (fixed) begin
			p.f[9] = longint'(zm);
			p.f[10] = longint'(yw);
			p.f[11] = longint'(pt);
		end
		pending_poses.push_back(p);
		@(negedge clk);
		// a following word raises valid again in this same step
		in_ch.valid = 1'b0;
	endtask

	function automatic event_t random_event();
		event_t ev;
		int     pick;
		ev.mx = 16'($urandom); ev.my = 16'($urandom); ev.dir = 2'($urandom);
		ev.dt = 16'($urandom); ev.scr = 24'($urandom);
		pick = $urandom_range(99);
		if (pick < 38) ev.op = OP_MOUSE;
		else if (pick < 68) ev.op = OP_KEY;
		else if (pick < 82) ev.op = OP_SCROLL;
		else if (pick < 91) ev.op = OP_SETPOS;
		else if (pick < 96) ev.op = OP_REINIT;
		else ev.op = 3'($urandom_range(5, 7));
		// half the mouse moves are small hand-sized motions around the last cursor position
		if (ev.op == OP_MOUSE && $urandom_range(1)) begin
			ev.mx = 16'(last_mx + $signed($urandom_range(400)) - 200);
			ev.my = 16'(last_my + $signed($urandom_range(400)) - 200);
		end
		if (ev.op == OP_SCROLL && $urandom_range(1))
			ev.scr = 24'($signed($urandom_range(20 * 65536)) - 10 * 65536);
		if (ev.op == OP_KEY && $urandom_range(3) == 0)
			ev.dt = 16'($urandom_range(2000));
		return ev;
	endfunction

	task automatic random_run(input int n);
		for (int i = 0; i < n; i++)
			send_event(random_event(), 1'b0, '0, '0, '0);
	endtask

	function automatic void set_idling(int mode);
		case (mode)
			0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin sender_idle_pct = 54; recv_stall_pct = 0;  end
			2: begin sender_idle_pct = 0;  recv_stall_pct = 54; end
			default: begin sender_idle_pct = 25; recv_stall_pct = 25; end
		endcase
	endfunction

	step_row_t steps [19];
	event_t    reinit_ev;

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_ch.valid = 1'b0; in_ch.opcode = OP_SCROLL; in_ch.mouse_x = '0; in_ch.mouse_y = '0;
		in_ch.direction = DIR_FWD; in_ch.delta_time = '0; in_ch.scroll_offset = '0;
		out_ch.ready = 1'b0;

		speed_q = 24'd163840; sens_q = 16'd6554; yaw0_q = -26'sd5898240; pitch0_q = '0;
		zoom0_q = 22'd2949120; x0_q = '0; y0_q = '0; z0_q = '0;
		last_mx = 0; last_my = 0;
		reload_camera();

		steps = '{
			'{'{OP_SCROLL, 16'd0, 16'd0, DIR_FWD, 16'd0, 24'sd0}, 1, 22'd2949120, -26'sd5898240, 26'sd0},
			'{'{OP_SCROLL, 16'd0, 16'd0, DIR_FWD, 16'd0, 24'sd8388607}, 1, 22'd65536, -26'sd5898240, 26'sd0},
			'{'{OP_SCROLL, 16'd0, 16'd0, DIR_FWD, 16'd0, -24'sd8388608}, 1, 22'd2949120, -26'sd5898240, 26'sd0},
			'{'{OP_SETPOS, 16'd0, 16'd0, DIR_FWD, 16'd0, 24'sd0}, 0, '0, '0, '0},
			'{'{OP_MOUSE, 16'hFFFF, 16'hFFFF, DIR_FWD, 16'd0, 24'sd0}, 1, 22'd2949120, 26'sd17694720, 26'sd23592960},
			'{'{OP_SETPOS, 16'hFFFF, 16'hFFFF, DIR_FWD, 16'd0, 24'sd0}, 0, '0, '0, '0},
			'{'{OP_MOUSE, 16'd0, 16'd0, DIR_FWD, 16'd0, 24'sd0}, 1, 22'd2949120, -26'sd5898240, 26'sd0},
			'{'{OP_KEY, 16'd0, 16'd0, DIR_FWD, 16'hFFFF, 24'sd0}, 0, '0, '0, '0},
			'{'{OP_KEY, 16'd0, 16'd0, DIR_BACK, 16'hFFFF, 24'sd0}, 0, '0, '0, '0},
			'{'{OP_KEY, 16'd0, 16'd0, DIR_LEFT, 16'hFFFF, 24'sd0}, 0, '0, '0, '0},
			'{'{OP_KEY, 16'd0, 16'd0, DIR_RIGHT, 16'hFFFF, 24'sd0}, 0, '0, '0, '0},
			'{'{OP_KEY, 16'hFFFF, 16'hFFFF, DIR_FWD, 16'd0, 24'sd0}, 0, '0, '0, '0},
			'{'{OP_MOUSE, 16'd100, 16'd50, DIR_FWD, 16'd0, 24'sd0}, 0, '0, '0, '0},
			'{'{OP_KEY, 16'd0, 16'd0, DIR_LEFT, 16'd30000, 24'sd0}, 0, '0, '0, '0},
			'{'{OP_REINIT, 16'd0, 16'd0, DIR_FWD, 16'd0, 24'sd0}, 1, 22'd2949120, -26'sd5898240, 26'sd0},
			'{'{OP_SPARE5, 16'hFFFF, 16'hFFFF, DIR_RIGHT, 16'hFFFF, -24'sd1}, 0, '0, '0, '0},
			'{'{OP_SPARE6, 16'd0, 16'd0, DIR_FWD, 16'd0, 24'sd0}, 0, '0, '0, '0},
			'{'{OP_SPARE7, 16'hFFFF, 16'hFFFF, DIR_RIGHT, 16'hFFFF, -24'sd1}, 0, '0, '0, '0},
			'{'{OP_MOUSE, 16'd120, 16'd10, DIR_FWD, 16'd0, 24'sd0}, 0, '0, '0, '0}
		};
		reinit_ev = '{OP_REINIT, 16'd0, 16'd0, DIR_FWD, 16'd0, 24'sd0};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		set_idling(0);
		foreach (steps[i])
			send_event(steps[i].ev, steps[i].fixed, steps[i].zoom, steps[i].yaw, steps[i].pitch);
		random_run(100);

		// extremes: fastest motion, coarsest turn, eye pinned at the corners
		load_regs(24'hFFFFFF, 16'hFFFF, 26'sd23592960, 26'sd23592960, 22'd65536,
			32'sh7FFFFFFF, 32'sh80000000, 32'sd0);
		set_idling(1);
		send_event(reinit_ev, 1'b0, '0, '0, '0);
		random_run(130);

		// everything stopped, negative extremes; long receiver hold-off
		load_regs(24'd0, 16'd0, -26'sd23592960, -26'sd23592960, 22'd2949120,
			-32'sd1, 32'sd1, 32'sh7FFFFFFF);
		set_idling(2);
		hold_cnt = 400;
		send_event(reinit_ev, 1'b0, '0, '0, '0);
		random_run(130);

		// looking straight up, zoom register above its clamp
		load_regs(24'd655360, 16'd1000, 26'sd0, 26'sd5898240, 22'h3FFFFF,
			32'sd0, 32'sd0, 32'sd0);
		set_idling(3);
		send_event(reinit_ev, 1'b0, '0, '0, '0);
		random_run(130);

		// straight down, zoom register below its clamp
		load_regs(24'd196608, 16'd300, 26'sd11796480, -26'sd5898240, 22'd0,
			32'($urandom), 32'($urandom), 32'($urandom));
		set_idling(0);
		send_event(reinit_ev, 1'b0, '0, '0, '0);
		random_run(60);
		set_idling(3);
		random_run(60);

		in_ch.valid = 1'b0;
		wait (pending_poses.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (err_cnt == 0 && pending_poses.size() == 0)
			$display("euler_camera_orientation_unit regression: pass");
		else
			$display("euler_camera_orientation_unit regression: fail");
		$finish;
	end

endmodule
